// ===== rtl/mse_pkg.sv =====
// mse_pkg: opcodes, function codes, status codes and the execute result type
// for the mips subset execute block; no dependencies
`default_nettype none

package mse_pkg;

  localparam int unsigned NumRegs = 32;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_XOR = 6'd38;

  typedef enum logic [2:0] {
    ST_ALU    = 3'd0,
    ST_ADDI   = 3'd1,
    ST_LOAD   = 3'd2,
    ST_STORE  = 3'd3,
    ST_BRANCH = 3'd4,
    ST_NOP    = 3'd5,
    ST_FAULT  = 3'd6
  } status_e;

  typedef struct packed {
    status_e     status;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [31:0] mem_value;
    logic        branch_taken;
  } exec_res_t;

endpackage

`default_nettype wire

// ===== rtl/mips_subset_execute_top.sv =====
// mips_subset_execute_top: executes one mips subset instruction word per cycle when not stalled
// against a synchronous register file and data memory; uses mse_pkg
`default_nettype none

//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  input     | in_valid_i, in_stall_o, instruction_i    | in
//  result    | out_valid_o, out_stall_i, status_o, ...  | out
//
// one word per cycle sustained while the output is not stalled; the edge that
// takes a word also does the synchronous register file and data memory reads,
// and the edge on which the word advances does execute, write back and the
// output register.
// writes of the word in execute are forwarded to the word being read.
// after reset a clearing pass loads register i with i and memory word a with a;
// no word is taken until it ends.
// a stalled output holds the result; execute holds behind it.

module mips_subset_execute_top import mse_pkg::*; #(
  parameter int unsigned MEM_WORDS = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [31:0]        instruction_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic                    reg_written_o,
  output logic [4:0]              reg_index_o,
  output logic signed [31:0]      reg_value_o,
  output logic                    mem_written_o,
  output logic [15:0]             mem_address_o,
  output logic signed [31:0]      mem_value_o,
  output logic                    branch_taken_o
);

  localparam int unsigned AW     = $clog2(MEM_WORDS);
  localparam int unsigned ClrLen = (MEM_WORDS > NumRegs) ? MEM_WORDS : NumRegs;
  localparam int unsigned CW     = $clog2(ClrLen + 1);
  localparam logic [16:0] MemLimit = 17'(MEM_WORDS);

  // storage
  logic [31:0] rf_mem [NumRegs];
  logic [31:0] dm_mem [MEM_WORDS];

  // clearing pass
  logic          clr_busy_q, clr_busy_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;

  // pipeline control
  logic        accept;
  logic        advance;
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_instr_q;
  logic        out_valid_q, out_valid_d;
  exec_res_t   out_res_q;

  // read data and forwarding
  logic [31:0] rf_a_q, rf_b_q, dm_q;
  logic        fwd_a_q, fwd_b_q, fwd_m_q;
  logic [31:0] fwd_rf_q, fwd_dm_q;

  // input decode for read addresses
  logic [4:0]  in_rs, in_rt;
  logic [15:0] in_imm;
  logic        in_mem_ok;

  // execute
  logic [5:0]  ex_op, ex_fn;
  logic [4:0]  ex_rt, ex_rd;
  logic [15:0] ex_imm;
  logic [31:0] ex_a, ex_b, ex_m;
  logic        ex_in_range;
  exec_res_t   ex_res;

  // write ports
  logic              rf_we, dm_we;
  logic [4:0]        rf_wa;
  logic [AW-1:0]     dm_wa;
  logic [31:0]       rf_wd, dm_wd;

  assign in_rs     = instruction_i[25:21];
  assign in_rt     = instruction_i[20:16];
  assign in_imm    = instruction_i[15:0];
  assign in_mem_ok = {1'b0, in_imm} < MemLimit;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (s1_valid_q && !advance);
  assign accept     = in_valid_i && !in_stall_o;

  // control registers
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + CW'(1);
      if (clr_cnt_q == CW'(ClrLen - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    s1_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // write port selection: clearing pass or execute write back
  always_comb begin
    if (clr_busy_q) begin
      rf_we = clr_cnt_q < CW'(NumRegs);
      rf_wa = clr_cnt_q[4:0];
      rf_wd = {{(32-CW){1'b0}}, clr_cnt_q};
      dm_we = clr_cnt_q < CW'(MEM_WORDS);
      dm_wa = clr_cnt_q[AW-1:0];
      dm_wd = {{(32-CW){1'b0}}, clr_cnt_q};
    end else begin
      rf_we = advance && ex_res.reg_written;
      rf_wa = ex_res.reg_index;
      rf_wd = ex_res.reg_value;
      dm_we = advance && ex_res.mem_written;
      dm_wa = ex_res.mem_address[AW-1:0];
      dm_wd = ex_res.mem_value;
    end
  end

  // register file: one write, two reads
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (accept) begin
      rf_a_q <= rf_mem[in_rs];
      rf_b_q <= rf_mem[in_rt];
    end
  end

  // data memory: one write, one read
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
    if (accept && in_mem_ok) begin
      dm_q <= dm_mem[in_imm[AW-1:0]];
    end
  end

  // forwarding of the write that lands on the same edge as the read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_instr_q <= instruction_i;
      fwd_a_q    <= rf_we && (rf_wa == in_rs);
      fwd_b_q    <= rf_we && (rf_wa == in_rt);
      fwd_m_q    <= dm_we && in_mem_ok && (dm_wa == in_imm[AW-1:0]);
      fwd_rf_q   <= rf_wd;
      fwd_dm_q   <= dm_wd;
    end
    if (advance) begin
      out_res_q <= ex_res;
    end
  end

  // execute
  assign ex_op  = s1_instr_q[31:26];
  assign ex_rt  = s1_instr_q[20:16];
  assign ex_rd  = s1_instr_q[15:11];
  assign ex_fn  = s1_instr_q[5:0];
  assign ex_imm = s1_instr_q[15:0];
  assign ex_a   = fwd_a_q ? fwd_rf_q : rf_a_q;
  assign ex_b   = fwd_b_q ? fwd_rf_q : rf_b_q;
  assign ex_m   = fwd_m_q ? fwd_dm_q : dm_q;
  assign ex_in_range = {1'b0, ex_imm} < MemLimit;

  always_comb begin
    ex_res = '0;
    ex_res.status = ST_NOP;
    unique case (ex_op)
      OP_RTYPE: begin
        ex_res.reg_index = ex_rd;
        unique case (ex_fn)
          FN_ADD:  ex_res.reg_value = ex_a + ex_b;
          FN_SUB:  ex_res.reg_value = ex_a - ex_b;
          FN_AND:  ex_res.reg_value = ex_a & ex_b;
          FN_OR:   ex_res.reg_value = ex_a | ex_b;
          FN_XOR:  ex_res.reg_value = ex_a ^ ex_b;
          default: ex_res.reg_index = '0;
        endcase
        if (ex_fn == FN_ADD || ex_fn == FN_SUB || ex_fn == FN_AND ||
            ex_fn == FN_OR || ex_fn == FN_XOR) begin
          ex_res.status      = ST_ALU;
          ex_res.reg_written = 1'b1;
        end
      end
      OP_ADDI: begin
        ex_res.status      = ST_ADDI;
        ex_res.reg_written = 1'b1;
        ex_res.reg_index   = ex_rt;
        ex_res.reg_value   = ex_a + {16'd0, ex_imm};
      end
      OP_LW: begin
        ex_res.mem_address = ex_imm;
        if (!ex_in_range) begin
          ex_res.status = ST_FAULT;
        end else begin
          ex_res.status      = ST_LOAD;
          ex_res.reg_written = 1'b1;
          ex_res.reg_index   = ex_rt;
          ex_res.reg_value   = ex_m;
        end
      end
      OP_SW: begin
        ex_res.mem_address = ex_imm;
        if (!ex_in_range) begin
          ex_res.status = ST_FAULT;
        end else begin
          ex_res.status      = ST_STORE;
          ex_res.mem_written = 1'b1;
          ex_res.mem_value   = ex_b;
        end
      end
      OP_BEQ: begin
        ex_res.status       = ST_BRANCH;
        ex_res.branch_taken = ex_a == ex_b;
      end
      OP_BNE: begin
        ex_res.status       = ST_BRANCH;
        ex_res.branch_taken = ex_a != ex_b;
      end
      default: ex_res.status = ST_NOP;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign reg_written_o  = out_res_q.reg_written;
  assign reg_index_o    = out_res_q.reg_index;
  assign reg_value_o    = out_res_q.reg_value;
  assign mem_written_o  = out_res_q.mem_written;
  assign mem_address_o  = out_res_q.mem_address;
  assign mem_value_o    = out_res_q.mem_value;
  assign branch_taken_o = out_res_q.branch_taken;

  // checks
  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_valid_q && !out_valid_q))
    else $error("word in flight during clearing pass");

  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.status == ST_FAULT) |->
      (!out_res_q.reg_written && !out_res_q.mem_written))
    else $error("address fault with a write");

  a_reg_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.reg_written) |->
      (out_res_q.status == ST_ALU || out_res_q.status == ST_ADDI ||
       out_res_q.status == ST_LOAD))
    else $error("register write with wrong status");

  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> s1_valid_q)
    else $error("execute word lost under output stall");

endmodule

`default_nettype wire
